>>> rtl/monochrome_framebuffer_fill_and_flush_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared assertion helpers for the framebuffer block.
// ---------------------------------------------------------------------------
`ifndef MONOCHROME_FRAMEBUFFER_FILL_AND_FLUSH_DEFINES_SVH
`define MONOCHROME_FRAMEBUFFER_FILL_AND_FLUSH_DEFINES_SVH
`ifndef ASSERT_OFF
`define MFB_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MFB_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) cond |=> nxt) else $error(msg);
`else
`define MFB_ASSERT(label, clk, rst_n, prop, msg)
`define MFB_ASSERT_NEXT(label, clk, rst_n, cond, nxt, msg)
`endif
`endif

>>> rtl/mfb_pkg.sv
// ---------------------------------------------------------------------------
// Framebuffer package
// Types and constants shared by the framebuffer modules.
// ---------------------------------------------------------------------------
`default_nettype none
package mfb_pkg;
    localparam int SCREEN_WIDTH  = 128;
    localparam int SCREEN_HEIGHT = 32;
    localparam int CHUNK_BYTES   = 64;
    localparam int CMD_DEPTH     = 2;
    localparam int XW = 8;
    localparam int YW = 6;
    localparam int RW = $clog2(SCREEN_HEIGHT);
    localparam int BW = $clog2(CHUNK_BYTES);
    localparam int CBITS = CHUNK_BYTES * 8;

    typedef enum logic {
        OP_FILL  = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef struct packed {
        t_op          op;
        logic [XW-1:0] x;
        logic [YW-1:0] y;
        logic [XW-1:0] w;
        logic [YW-1:0] h;
        logic         color;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FILL,
        ST_SHAPE,
        ST_GATHER,
        ST_EMIT,
        ST_EMPTY
    } t_state;
endpackage
`default_nettype wire

>>> rtl/mfb_if.sv
// ---------------------------------------------------------------------------
// Framebuffer channels
// Valid/ready channels for input items and result beats.
// ---------------------------------------------------------------------------
`default_nettype none
interface mfb_in_if;
    logic        valid;
    logic        ready;
    logic        mode;
    logic [15:0] rect_x;
    logic [15:0] rect_y;
    logic [15:0] rect_w;
    logic [15:0] rect_h;
    logic        color;
    modport source (output valid, mode, rect_x, rect_y, rect_w, rect_h, color, input ready);
    modport sink (input valid, mode, rect_x, rect_y, rect_w, rect_h, color, output ready);
endinterface

interface mfb_out_if;
    logic       valid;
    logic       ready;
    logic       has_data;
    logic [7:0] chunk_x;
    logic [5:0] chunk_y;
    logic [7:0] chunk_w;
    logic [5:0] chunk_h;
    logic [7:0] data_byte;
    logic       last;
    modport source (output valid, has_data, chunk_x, chunk_y, chunk_w, chunk_h, data_byte,
        last, input ready);
    modport sink (input valid, has_data, chunk_x, chunk_y, chunk_w, chunk_h, data_byte,
        last, output ready);
endinterface
`default_nettype wire

>>> rtl/mfb_front.sv
// ---------------------------------------------------------------------------
// Framebuffer front end
// Clips fill rectangles, drops empty ones and queues commands.
// ---------------------------------------------------------------------------
`default_nettype none
module mfb_front
    import mfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mfb_in_if.sink    i_in,
    output t_cmd      o_cmd,
    output logic      o_cmd_valid,
    input  wire logic i_cmd_pop
);
    t_cmd       r_q [CMD_DEPTH];
    logic [1:0] r_cnt;
    logic       r_rd;
    logic       r_wr;
    logic signed [17:0] x0, y0, w0, h0, x1, y1, w1, h1;
    logic keep;
    t_cmd cmd;
    logic push;

    always_comb begin
        x0 = 18'(signed'(i_in.rect_x));
        y0 = 18'(signed'(i_in.rect_y));
        w0 = 18'(signed'(i_in.rect_w));
        h0 = 18'(signed'(i_in.rect_h));
        x1 = x0; w1 = w0; y1 = y0; h1 = h0;
        if (x0 < 0) begin
            w1 = w0 + x0;
            x1 = '0;
        end
        if (y0 < 0) begin
            h1 = h0 + y0;
            y1 = '0;
        end
        keep = (w1 > 0) && (h1 > 0) && (x1 < SCREEN_WIDTH) && (y1 < SCREEN_HEIGHT);
        if (x1 + w1 > SCREEN_WIDTH) w1 = 18'(SCREEN_WIDTH) - x1;
        if (y1 + h1 > SCREEN_HEIGHT) h1 = 18'(SCREEN_HEIGHT) - y1;
        cmd.op = t_op'(i_in.mode);
        cmd.x = XW'(x1);
        cmd.y = YW'(y1);
        cmd.w = XW'(w1);
        cmd.h = YW'(h1);
        cmd.color = i_in.color;
        if (i_in.mode == OP_FLUSH) keep = 1'b1;
    end

    assign i_in.ready = (r_cnt != 2'(CMD_DEPTH));
    assign push = i_in.valid && i_in.ready && keep;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_rd <= 1'b0;
            r_wr <= 1'b0;
        end else begin
            if (push) begin
                r_q[r_wr] <= cmd;
                r_wr <= ~r_wr;
            end
            if (i_cmd_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + 2'(push) - 2'(i_cmd_pop);
        end
    end
endmodule
`default_nettype wire

>>> rtl/mfb_back.sv
// ---------------------------------------------------------------------------
// Framebuffer back end
// Holds the frame memory and dirty rectangle, fills rows and emits chunks.
// ---------------------------------------------------------------------------
`default_nettype none
`include "monochrome_framebuffer_fill_and_flush_defines.svh"
module mfb_back
    import mfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  t_cmd      i_cmd,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_pop,
    mfb_out_if.source o_out
);
    // Row r of memory holds screen row SCREEN_HEIGHT-1-r, bit c is column 127-c.
    logic [SCREEN_WIDTH-1:0] r_mem [SCREEN_HEIGHT];
    logic [SCREEN_HEIGHT-1:0] r_vld;
    logic [SCREEN_WIDTH-1:0] r_rdata;
    t_state r_st, n_st;
    t_cmd   r_cmd;
    logic [XW-1:0] r_dl, r_dw, r_sw, r_cx;
    logic [YW-1:0] r_dt, r_dh, r_sh, r_cy;
    logic [RW:0]   r_row;
    logic [RW:0]   r_cnt;
    logic          r_rdv;
    logic [CBITS-1:0] r_buf;
    logic [9:0]    r_pos;
    logic [BW:0]   r_size, r_idx;
    logic          r_ov;
    logic [7:0]    r_ox, r_ow, r_ob;
    logic [5:0]    r_oy, r_oh;
    logic          r_ohd, r_olast;

    logic [SCREEN_WIDTH-1:0] mask, row_val, gath, rrev;
    logic [13:0] area;
    logic [BW+1:0] sz;
    logic fits;
    logic [XW:0] ex2, dx2, nx2;
    logic [YW:0] ey2, dy2, ny2;
    logic [XW-1:0] nl;
    logic [YW-1:0] nt;
    logic take;
    logic [RW-1:0] mrow;

    assign take = !r_ov || o_out.ready;
    assign area = 14'(r_sw) * 14'(r_sh);
    assign sz = (BW+2)'((area + 14'd7) >> 3);
    assign fits = (area + 14'd7) <= 14'(CBITS + 7);

    always_comb begin
        for (int c = 0; c < SCREEN_WIDTH; c++) begin
            mask[c] = (SCREEN_WIDTH - 1 - c >= int'(r_cmd.x)) &&
                (SCREEN_WIDTH - 1 - c < int'(r_cmd.x) + int'(r_cmd.w));
        end
        for (int c = 0; c < SCREEN_WIDTH; c++) begin
            rrev[c] = r_rdata[SCREEN_WIDTH - 1 - c];
        end
        row_val = r_vld[r_row[RW-1:0]] ? r_mem[r_row[RW-1:0]] : '0;
        gath = (rrev >> r_dl) & ((SCREEN_WIDTH'(1) << r_sw) - SCREEN_WIDTH'(1));
        nl = (r_cmd.x < r_dl) ? r_cmd.x : r_dl;
        nt = (r_cmd.y < r_dt) ? r_cmd.y : r_dt;
        ex2 = (XW+1)'(r_cmd.x) + (XW+1)'(r_cmd.w);
        ey2 = (YW+1)'(r_cmd.y) + (YW+1)'(r_cmd.h);
        dx2 = (XW+1)'(r_dl) + (XW+1)'(r_dw);
        dy2 = (YW+1)'(r_dt) + (YW+1)'(r_dh);
        nx2 = (dx2 < ex2) ? ex2 : dx2;
        ny2 = (dy2 < ey2) ? ey2 : dy2;
        mrow = RW'(SCREEN_HEIGHT - 1) - RW'(r_dt) - RW'(r_cnt);
    end

    always_comb begin
        n_st = r_st;
        o_cmd_pop = 1'b0;
        unique case (r_st)
            ST_IDLE: begin
                if (i_cmd_valid) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.op == OP_FILL) n_st = ST_FILL;
                    else if (r_dw == '0 || r_dh == '0) n_st = ST_EMPTY;
                    else n_st = ST_SHAPE;
                end
            end
            ST_FILL: if (r_cnt == (RW+1)'(r_cmd.h)) n_st = ST_IDLE;
            ST_SHAPE: if (fits || (r_dw > 8'(r_dh) ? r_sw == 8'd1 : r_sh == 6'd1))
                n_st = ST_GATHER;
            ST_GATHER: if (r_rdv && r_cnt == (RW+1)'(r_sh)) n_st = ST_EMIT;
            ST_EMIT: if (take && r_idx + 1'b1 == r_size) n_st = ST_IDLE;
            ST_EMPTY: if (take) n_st = ST_IDLE;
            default: n_st = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_vld[mrow] ? r_mem[mrow] : '0;
        if (r_st == ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        if (r_st == ST_FILL && r_cnt != (RW+1)'(r_cmd.h)) begin
            r_mem[r_row[RW-1:0]] <= r_cmd.color ? (row_val | mask) : (row_val & ~mask);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_IDLE;
            r_vld <= '0;
            r_dl <= '0; r_dt <= '0;
            r_dw <= 8'(SCREEN_WIDTH);
            r_dh <= 6'(SCREEN_HEIGHT);
            r_cnt <= '0; r_row <= '0; r_rdv <= 1'b0;
            r_ov <= 1'b0;
            r_cx <= '0; r_cy <= '0;
            r_sw <= '0; r_sh <= '0; r_pos <= '0; r_size <= '0; r_idx <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= (r_st == ST_EMIT || r_st == ST_EMPTY) ? 1'b1 : (r_ov && !o_out.ready);
            unique case (r_st)
                ST_IDLE: begin
                    r_cnt <= '0;
                    r_rdv <= 1'b0;
                    r_idx <= '0;
                    r_sw <= r_dw; r_sh <= r_dh;
                    r_cx <= r_dl; r_cy <= r_dt;
                    r_row <= (RW+1)'(SCREEN_HEIGHT - 1) - (RW+1)'(i_cmd.y);
                end
                ST_FILL: begin
                    if (r_cnt == '0) begin
                        r_dl <= nl; r_dt <= nt;
                        r_dw <= XW'(nx2 - (XW+1)'(nl));
                        r_dh <= YW'(ny2 - (YW+1)'(nt));
                    end
                    if (r_cnt != (RW+1)'(r_cmd.h)) begin
                        r_vld[r_row[RW-1:0]] <= 1'b1;
                        r_row <= r_row - 1'b1;
                        r_cnt <= r_cnt + 1'b1;
                    end
                end
                ST_SHAPE: begin
                    r_buf <= '0;
                    r_pos <= 10'((14'(sz) << 3) - area);
                    r_size <= fits ? (BW+1)'(sz) : (BW+1)'(CHUNK_BYTES);
                    if (!fits) begin
                        if (r_dw > 8'(r_dh)) begin
                            if (r_sw != 8'd1) r_sw <= r_sw - 1'b1;
                        end else if (r_sh != 6'd1) r_sh <= r_sh - 1'b1;
                    end
                end
                ST_GATHER: begin
                    if (r_cnt != (RW+1)'(r_sh)) r_cnt <= r_cnt + 1'b1;
                    r_rdv <= (r_cnt != (RW+1)'(r_sh));
                    if (r_rdv) begin
                        // Top row lands lowest, so the buffer holds the stream reversed.
                        r_buf <= r_buf | (CBITS'(gath) << (CBITS'(r_pos)));
                        r_pos <= r_pos + 10'(r_sw);
                    end
                    if (n_st == ST_EMIT) begin
                        if (r_sw != r_dw) begin
                            r_dl <= r_dl + r_sw; r_dw <= r_dw - r_sw;
                        end else begin
                            r_dt <= r_dt + r_sh; r_dh <= r_dh - r_sh;
                        end
                    end
                end
                ST_EMIT: begin
                    if (take) begin
                        r_ohd <= 1'b1;
                        r_ox <= r_cx;
                        r_oy <= r_cy;
                        r_ow <= r_sw; r_oh <= r_sh;
                        r_ob <= r_buf[{r_idx[BW-1:0], 3'b000} +: 8];
                        r_olast <= (r_idx + 1'b1 == r_size);
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_EMPTY: begin
                    if (take) begin
                        r_ohd <= 1'b0; r_ox <= '0; r_oy <= '0; r_ow <= '0; r_oh <= '0;
                        r_ob <= '0; r_olast <= 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_out.valid = r_ov;
    assign o_out.has_data = r_ohd;
    assign o_out.chunk_x = r_ox;
    assign o_out.chunk_y = r_oy;
    assign o_out.chunk_w = r_ow;
    assign o_out.chunk_h = r_oh;
    assign o_out.data_byte = r_ob;
    assign o_out.last = r_olast;

    `MFB_ASSERT(a_pop_idle, i_clk, i_rst_n, o_cmd_pop |-> r_st == ST_IDLE, "pop outside idle")
    `MFB_ASSERT(a_dirty_h, i_clk, i_rst_n, 1'b1 |-> 7'(r_dh) + 7'(r_dt) <= 7'(SCREEN_HEIGHT) || r_dh == '0, "dirty rows off screen")
    `MFB_ASSERT_NEXT(a_emit_out, i_clk, i_rst_n, r_st == ST_EMIT && take, r_ov && r_ohd, "emit lost")
endmodule
`default_nettype wire

>>> rtl/monochrome_framebuffer_fill_and_flush.sv
// A fill writes one framebuffer row per cycle in the back end. A flush runs the shape
// loop and the row gather, then emits one byte per cycle while the output accepts.
// Throughput is set by the shape loop and the row count.
// The input queue holds two items, so the front accepts while the back works.
// Reset is synchronous active low; frame rows read as cleared until written.
// ---------------------------------------------------------------------------
// Monochrome framebuffer fill and flush
// Top level: front end, command queue and back end.
// ---------------------------------------------------------------------------
`default_nettype none
module monochrome_framebuffer_fill_and_flush
    import mfb_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    mfb_in_if.sink    i_in,
    mfb_out_if.source o_out
);
    t_cmd cmd;
    logic cmd_valid, cmd_pop;

    mfb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(i_in),
        .o_cmd(cmd), .o_cmd_valid(cmd_valid), .i_cmd_pop(cmd_pop)
    );
    mfb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .i_cmd_valid(cmd_valid),
        .o_cmd_pop(cmd_pop), .o_out(o_out)
    );
endmodule
`default_nettype wire
